@@ rtl/quad_trimmed_mean_window_filter_macros.svh @@
// Assertion macros shared by the trimmed mean filter RTL.
`ifndef QUAD_TRIMMED_MEAN_WINDOW_FILTER_MACROS_SVH
`define QUAD_TRIMMED_MEAN_WINDOW_FILTER_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define QTMWF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must hold in the cycle after a trigger.
`define QTMWF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QTMWF_ASSERT(lbl, prop, msg)
`define QTMWF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/qtmwf_pkg.sv @@
// Package with constants, register indexes and state type of the trimmed mean filter.
`timescale 1ns / 1ps

package qtmwf_pkg;

    // Field widths fixed by the stream format.
    localparam int SAMPLE_BITS    = 10;
    localparam int MAX_CH         = 4;
    localparam int TARE_BITS      = 10;
    localparam int GAIN_BITS      = 16;
    localparam int SMOOTH_BITS    = 10;
    localparam int LEVEL_BITS     = 19;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int S_DATA_BITS    = 40;
    localparam int M_DATA_BITS    = 120;

    // Reset value of the gain register: 1.0 in Q8.8.
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd256;

    // Default sizes handed to the top level.
    localparam int KEPT_SAMPLES_DEF = 8;
    localparam int DROP_LOW_DEF     = 1;
    localparam int DROP_HIGH_DEF    = 1;
    localparam int CHANNELS_DEF     = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARE_CH0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARE_CH3 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAL_GAIN = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_CALC,
        ST_DONE
    } qtmwf_state_t;

endpackage

@@ rtl/quad_trimmed_mean_window_filter.sv @@
// Top level of the four-channel moving trimmed mean filter with tare and gain.
`timescale 1ns / 1ps
//
// Channel   Signals                                   Moves
// --------  ----------------------------------------  ------------------------------
// input     s_tvalid / s_tready / s_tdata             one sample per channel
// output    m_tvalid / m_tready / m_tdata             trimmed means and levels
// config    cfg_valid / cfg_ready / cfg_index / data  tare and gain register writes
//
// For each request the window memory is read one row per cycle, then one shared
// divide-and-gain pipe handles one channel per cycle. The window rows are cleared at
// reset through per-row valid bits, so no clearing pass is needed. A new request is
// taken once the previous one has moved into the output register, even while that
// result still waits.

`include "quad_trimmed_mean_window_filter_macros.svh"

module quad_trimmed_mean_window_filter #(
    parameter int KEPT_SAMPLES = qtmwf_pkg::KEPT_SAMPLES_DEF,
    parameter int DROP_LOW     = qtmwf_pkg::DROP_LOW_DEF,
    parameter int DROP_HIGH    = qtmwf_pkg::DROP_HIGH_DEF,
    parameter int CHANNELS     = qtmwf_pkg::CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sample_ch0 [9:0], sample_ch1 [19:10], sample_ch2 [29:20], sample_ch3 [39:30]
    input  logic [qtmwf_pkg::S_DATA_BITS-1:0]     s_tdata,
    // Output stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // smooth_ch0..3 [39:0] at 10 bits each, level_ch0..3 [115:40] at 19 bits each,
    // zero fill [119:116]
    output logic [qtmwf_pkg::M_DATA_BITS-1:0]     m_tdata,
    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [qtmwf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [qtmwf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int SB         = qtmwf_pkg::SAMPLE_BITS;
    localparam int WIN_LEN    = KEPT_SAMPLES + DROP_LOW + DROP_HIGH;
    localparam int ADDR_W     = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    localparam int ROW_W      = CHANNELS * SB;
    localparam int SAMPLE_MAX = (1 << SB) - 1;
    localparam int SUM_W      = $clog2(WIN_LEN * SAMPLE_MAX + 1);
    localparam int CNT_W      = $clog2(CHANNELS + 1);
    // Division by KEPT_SAMPLES as a multiply by a rounded-up reciprocal.
    localparam int RECIP_SHIFT = SUM_W + $clog2(KEPT_SAMPLES);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int MUL_W       = SUM_W + RECIP_W;
    localparam longint RECIP_L =
        ((longint'(1) << RECIP_SHIFT) + longint'(KEPT_SAMPLES) - 1) / KEPT_SAMPLES;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    // Level arithmetic.
    localparam int DIFF_W = SB + 1;
    localparam int PROD_W = DIFF_W + qtmwf_pkg::GAIN_BITS + 1;
    localparam int LB     = qtmwf_pkg::LEVEL_BITS;
    localparam int SMOOTH_BASE = 0;
    localparam int LEVEL_BASE  = qtmwf_pkg::MAX_CH * qtmwf_pkg::SMOOTH_BITS;

    // State and handshakes.
    qtmwf_pkg::qtmwf_state_t state_reg, state_next;
    logic in_accept;
    logic rd_en;
    logic calc_en;
    logic out_load;
    logic m_tvalid_reg;

    // Window memory and its row valid bits.
    logic [ROW_W-1:0]   win_mem [WIN_LEN];
    logic [WIN_LEN-1:0] win_vld_reg;
    logic [ADDR_W-1:0]  wr_pos_reg;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic [ROW_W-1:0]   rd_data_reg;
    logic               rd_vld_reg;
    logic               rd_pend_reg;

    // Per-channel accumulators.
    logic [SUM_W-1:0] sum_reg [CHANNELS];
    logic [SB-1:0]    lo_reg  [CHANNELS];
    logic [SB-1:0]    hi_reg  [CHANNELS];
    logic [SB-1:0]    lane_val [CHANNELS];

    // Divide and gain pipe.
    logic [CNT_W-1:0]  ch_cnt_reg;
    logic [SUM_W-1:0]  trim;
    logic [MUL_W-1:0]  mean_full;
    logic [SB-1:0]     mean_reg;
    logic [1:0]        tare_idx;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic [SB-1:0]     smooth_wrk_reg [CHANNELS];
    logic [LB-1:0]     level_wrk_reg  [CHANNELS];
    logic [SB-1:0]     smooth_out_reg [CHANNELS];
    logic [LB-1:0]     level_out_reg  [CHANNELS];

    // Configuration registers.
    logic [qtmwf_pkg::TARE_BITS-1:0] tare_reg [qtmwf_pkg::MAX_CH];
    logic [qtmwf_pkg::GAIN_BITS-1:0] gain_reg;

    // Configuration writes; indexes past the gain register are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < qtmwf_pkg::MAX_CH; i++)
            begin
                tare_reg[i] <= '0;
            end
            gain_reg <= qtmwf_pkg::GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index) inside
                [qtmwf_pkg::REG_TARE_CH0:qtmwf_pkg::REG_TARE_CH3]:
                begin
                    tare_reg[cfg_index[1:0]] <= cfg_data[qtmwf_pkg::TARE_BITS-1:0];
                end
                qtmwf_pkg::REG_CAL_GAIN:
                begin
                    gain_reg <= cfg_data[qtmwf_pkg::GAIN_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qtmwf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = qtmwf_pkg::ST_WALK;
                end
            end
            qtmwf_pkg::ST_WALK:
            begin
                if (rd_addr_reg == ADDR_W'(WIN_LEN - 1))
                begin
                    state_next = qtmwf_pkg::ST_DRAIN;
                end
            end
            qtmwf_pkg::ST_DRAIN:
            begin
                state_next = qtmwf_pkg::ST_CALC;
            end
            qtmwf_pkg::ST_CALC:
            begin
                if (ch_cnt_reg == CNT_W'(CHANNELS))
                begin
                    state_next = qtmwf_pkg::ST_DONE;
                end
            end
            qtmwf_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = qtmwf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qtmwf_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        calc_en  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            qtmwf_pkg::ST_IDLE:  s_tready = 1'b1;
            qtmwf_pkg::ST_WALK:  rd_en    = 1'b1;
            qtmwf_pkg::ST_CALC:  calc_en  = 1'b1;
            qtmwf_pkg::ST_DONE:  out_load = !m_tvalid_reg || m_tready;
            default:
            begin
            end
        endcase
    end

    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qtmwf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Window memory: write the new row on a request, read one row per walk cycle.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            win_mem[wr_pos_reg] <= s_tdata[ROW_W-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= win_mem[rd_addr_reg];
        end
    end

    // Row valid bits, ring position and read sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_vld_reg <= '0;
            wr_pos_reg  <= '0;
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            if (in_accept)
            begin
                win_vld_reg[wr_pos_reg] <= 1'b1;
                wr_pos_reg <= (wr_pos_reg == ADDR_W'(WIN_LEN - 1)) ? '0
                                                                   : wr_pos_reg + 1'b1;
                rd_addr_reg <= '0;
            end
            else if (rd_en)
            begin
                rd_vld_reg <= win_vld_reg[rd_addr_reg];
                if (rd_addr_reg != ADDR_W'(WIN_LEN - 1))
                begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                end
            end
        end
    end

    // Rows never written read as zero.
    always_comb
    begin
        for (int ln = 0; ln < CHANNELS; ln++)
        begin
            lane_val[ln] = rd_vld_reg ? rd_data_reg[ln*SB +: SB] : '0;
        end
    end

    // Sum, minimum and maximum per lane; lanes shift down while the pipe drains them.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int ln = 0; ln < CHANNELS; ln++)
            begin
                sum_reg[ln] <= '0;
                lo_reg[ln]  <= SB'(SAMPLE_MAX);
                hi_reg[ln]  <= '0;
            end
        end
        else if (rd_pend_reg)
        begin
            for (int ln = 0; ln < CHANNELS; ln++)
            begin
                sum_reg[ln] <= sum_reg[ln] + SUM_W'(lane_val[ln]);
                if (lane_val[ln] < lo_reg[ln])
                begin
                    lo_reg[ln] <= lane_val[ln];
                end
                if (lane_val[ln] > hi_reg[ln])
                begin
                    hi_reg[ln] <= lane_val[ln];
                end
            end
        end
        else if (calc_en)
        begin
            for (int ln = 0; ln < CHANNELS - 1; ln++)
            begin
                sum_reg[ln] <= sum_reg[ln+1];
                lo_reg[ln]  <= lo_reg[ln+1];
                hi_reg[ln]  <= hi_reg[ln+1];
            end
        end
    end

    // Stage one: drop the extremes and divide by the kept count.
    always_comb
    begin
        trim = sum_reg[0];
        if (DROP_LOW != 0)
        begin
            trim = trim - SUM_W'(lo_reg[0]);
        end
        if (DROP_HIGH != 0)
        begin
            trim = trim - SUM_W'(hi_reg[0]);
        end
        mean_full = MUL_W'(trim) * MUL_W'(RECIP);
    end

    // Stage two: subtract the tare and apply the Q8.8 gain, flooring the shift.
    assign tare_idx = 2'(CNT_W'(ch_cnt_reg - CNT_W'(1)));
    assign diff = $signed({1'b0, mean_reg}) - $signed({1'b0, tare_reg[tare_idx]});
    assign prod = PROD_W'(diff) * $signed({1'b0, gain_reg});

    // Channel counter stops at the channel count until the next request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cnt_reg <= '0;
        end
        else if (state_reg == qtmwf_pkg::ST_DRAIN)
        begin
            ch_cnt_reg <= '0;
        end
        else if (calc_en && (ch_cnt_reg != CNT_W'(CHANNELS)))
        begin
            ch_cnt_reg <= ch_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_en && (ch_cnt_reg < CNT_W'(CHANNELS)))
        begin
            mean_reg <= mean_full[RECIP_SHIFT +: SB];
        end
        if (calc_en && (ch_cnt_reg != '0))
        begin
            for (int ln = 0; ln < CHANNELS - 1; ln++)
            begin
                smooth_wrk_reg[ln] <= smooth_wrk_reg[ln+1];
                level_wrk_reg[ln]  <= level_wrk_reg[ln+1];
            end
            smooth_wrk_reg[CHANNELS-1] <= mean_reg;
            level_wrk_reg[CHANNELS-1]  <= prod[8 +: LB];
        end
        if (out_load)
        begin
            for (int ln = 0; ln < CHANNELS; ln++)
            begin
                smooth_out_reg[ln] <= smooth_wrk_reg[ln];
                level_out_reg[ln]  <= level_wrk_reg[ln];
            end
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // Pack the result; missing channels read as zero.
    always_comb
    begin
        m_tdata = '0;
        for (int ln = 0; ln < CHANNELS; ln++)
        begin
            m_tdata[SMOOTH_BASE + ln*qtmwf_pkg::SMOOTH_BITS +: qtmwf_pkg::SMOOTH_BITS] =
                smooth_out_reg[ln];
            m_tdata[LEVEL_BASE + ln*LB +: LB] = level_out_reg[ln];
        end
    end

    // Checks on the sequencer.
    `QTMWF_ASSERT(a_wr_pos_range, wr_pos_reg <= ADDR_W'(WIN_LEN - 1), "ring position out of window")
    `QTMWF_ASSERT_NEXT(a_row_marked, in_accept, win_vld_reg[$past(wr_pos_reg)], "row not marked valid")
    `QTMWF_ASSERT(a_cnt_range, ch_cnt_reg <= CNT_W'(CHANNELS), "channel counter overran")
    `QTMWF_ASSERT_NEXT(a_out_loaded, out_load, m_tvalid_reg, "result not presented after load")

endmodule
